@@ rtl/core/rdp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rdp_pkg
// Shared types, constants and lookup functions for the date header parser.
// ============================================================================
package rdp_pkg;

    // Fixed length of the date text
    localparam logic [4:0] DATE_LEN = 5'd29;

    // Byte positions with a check or a capture
    localparam logic [4:0] POS_WDAY     = 5'd3;
    localparam logic [4:0] POS_SP_WDAY  = 5'd4;
    localparam logic [4:0] POS_DAY_HI   = 5'd5;
    localparam logic [4:0] POS_DAY_LO   = 5'd6;
    localparam logic [4:0] POS_SP_DAY   = 5'd7;
    localparam logic [4:0] POS_MONTH    = 5'd11;
    localparam logic [4:0] POS_CENT_HI  = 5'd12;
    localparam logic [4:0] POS_CENT_LO  = 5'd13;
    localparam logic [4:0] POS_YEAR_HI  = 5'd14;
    localparam logic [4:0] POS_YEAR_LO  = 5'd15;
    localparam logic [4:0] POS_SP_YEAR  = 5'd16;
    localparam logic [4:0] POS_HOUR_HI  = 5'd17;
    localparam logic [4:0] POS_HOUR_LO  = 5'd18;
    localparam logic [4:0] POS_COLON1   = 5'd19;
    localparam logic [4:0] POS_MIN_HI   = 5'd20;
    localparam logic [4:0] POS_MIN_LO   = 5'd21;
    localparam logic [4:0] POS_COLON2   = 5'd22;
    localparam logic [4:0] POS_SEC_HI   = 5'd23;
    localparam logic [4:0] POS_SEC_LO   = 5'd24;
    localparam logic [4:0] POS_GMT      = 5'd28;

    // Error codes
    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_SHORT    = 4'd1;
    localparam logic [3:0] ERR_WDAY     = 4'd2;
    localparam logic [3:0] ERR_SP_WDAY  = 4'd3;
    localparam logic [3:0] ERR_DAY      = 4'd4;
    localparam logic [3:0] ERR_SP_DAY   = 4'd5;
    localparam logic [3:0] ERR_MONTH    = 4'd6;
    localparam logic [3:0] ERR_CENT     = 4'd7;
    localparam logic [3:0] ERR_YEAR     = 4'd8;
    localparam logic [3:0] ERR_SP_YEAR  = 4'd9;
    localparam logic [3:0] ERR_HOUR     = 4'd10;
    localparam logic [3:0] ERR_COLON1   = 4'd11;
    localparam logic [3:0] ERR_MIN      = 4'd12;
    localparam logic [3:0] ERR_COLON2   = 4'd13;
    localparam logic [3:0] ERR_SEC      = 4'd14;
    localparam logic [3:0] ERR_GMT      = 4'd15;

    // Characters and limits
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_COLON  = 8'h3a;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [3:0]  NOT_DIGIT = 4'd15;
    localparam logic [31:0] LOWER_MASK = 32'h20202020;
    localparam logic [31:0] GMT_WORD   = 32'h746d6720;
    localparam logic [6:0]  MAX_DAY    = 7'd31;
    localparam logic [6:0]  MAX_HOUR   = 7'd23;
    localparam logic [6:0]  MAX_MINSEC = 7'd59;
    localparam logic [6:0]  MAX_PAIR   = 7'd99;
    localparam logic [13:0] CENT_SCALE = 14'd100;
    localparam logic [13:0] YEAR_BASE  = 14'd1900;

    // Name words, first letter in the low byte, with trailing comma or space
    localparam logic [31:0] WDAY_WORDS [7] = '{
        32'h2c6e7553, 32'h2c6e6f4d, 32'h2c657554, 32'h2c646557,
        32'h2c756854, 32'h2c697246, 32'h2c746153
    };
    localparam logic [31:0] MONTH_WORDS [12] = '{
        32'h206e614a, 32'h20626546, 32'h2072614d, 32'h20727041,
        32'h2079614d, 32'h206e754a, 32'h206c754a, 32'h20677541,
        32'h20706553, 32'h2074634f, 32'h20766f4e, 32'h20636544
    };

    typedef struct packed {
        logic [2:0]  wday;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_fields;

    // Per-byte check outcome
    typedef struct packed {
        logic [3:0]  err;
        logic        wr_wday;
        logic        wr_day;
        logic        wr_month;
        logic        wr_year;
        logic        wr_hour;
        logic        wr_minute;
        logic        wr_second;
        logic        wr_cent;
        logic        wr_tens;
        logic [3:0]  tens;
        logic [6:0]  cent;
        t_fields     fld;
    } t_chk;

    typedef struct packed {
        logic        ok;
        logic [3:0]  code;
        t_fields     fld;
    } t_result;

    // {hit, index}
    function automatic logic [3:0] wday_lookup(input logic [31:0] word);
        logic [3:0] res;
        res = '0;
        for (int i = 0; i < 7; i++) begin
            if (word == WDAY_WORDS[i]) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    // {hit, index}
    function automatic logic [4:0] month_lookup(input logic [31:0] word);
        logic [4:0] res;
        res = '0;
        for (int i = 0; i < 12; i++) begin
            if (word == MONTH_WORDS[i]) begin
                res = {1'b1, 4'(i)};
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rdp_byte_check.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rdp_byte_check
// Position-indexed check of one byte: error code and field captures.
// ============================================================================
module rdp_byte_check
    import rdp_pkg::*;
(
    input  logic [4:0]  i_pos,
    input  logic [7:0]  i_byte,
    input  logic [23:0] i_recent,
    input  logic [3:0]  i_tens,
    input  logic [6:0]  i_cent,
    output t_chk        o_chk
);

    logic [31:0] word;
    logic        is_digit;
    logic        pair_ok;
    logic [6:0]  pair_v;
    logic [3:0]  wd_hit;
    logic [4:0]  mo_hit;
    logic [13:0] year_v;

    assign word     = {i_byte, i_recent};
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign pair_ok  = is_digit && (i_tens <= 4'd9);
    assign pair_v   = {3'b000, i_tens} * 7'd10 + {3'b000, i_byte[3:0]};
    assign wd_hit   = wday_lookup(word);
    assign mo_hit   = month_lookup(word);
    assign year_v   = {7'b0, i_cent} * CENT_SCALE + {7'b0, pair_v} - YEAR_BASE;

    always_comb begin
        o_chk            = '0;
        o_chk.fld.wday   = wd_hit[2:0];
        o_chk.fld.day    = pair_v[4:0];
        o_chk.fld.month  = mo_hit[3:0];
        o_chk.fld.year   = year_v;
        o_chk.fld.hour   = pair_v[4:0];
        o_chk.fld.minute = pair_v[5:0];
        o_chk.fld.second = pair_v[5:0];
        o_chk.cent       = pair_v;
        o_chk.tens       = is_digit ? i_byte[3:0] : NOT_DIGIT;
        case (i_pos)
            POS_WDAY: begin
                if (wd_hit[3]) o_chk.wr_wday = 1'b1;
                else           o_chk.err     = ERR_WDAY;
            end
            POS_SP_WDAY: if (i_byte != CH_SPACE) o_chk.err = ERR_SP_WDAY;
            POS_SP_DAY:  if (i_byte != CH_SPACE) o_chk.err = ERR_SP_DAY;
            POS_SP_YEAR: if (i_byte != CH_SPACE) o_chk.err = ERR_SP_YEAR;
            POS_COLON1:  if (i_byte != CH_COLON) o_chk.err = ERR_COLON1;
            POS_COLON2:  if (i_byte != CH_COLON) o_chk.err = ERR_COLON2;
            POS_MONTH: begin
                if (mo_hit[4]) o_chk.wr_month = 1'b1;
                else           o_chk.err      = ERR_MONTH;
            end
            POS_DAY_HI, POS_CENT_HI, POS_YEAR_HI, POS_HOUR_HI, POS_MIN_HI,
            POS_SEC_HI: o_chk.wr_tens = 1'b1;
            POS_DAY_LO: begin
                if (pair_ok && pair_v <= MAX_DAY) o_chk.wr_day = 1'b1;
                else                              o_chk.err    = ERR_DAY;
            end
            POS_CENT_LO: begin
                if (pair_ok && pair_v <= MAX_PAIR) o_chk.wr_cent = 1'b1;
                else                               o_chk.err     = ERR_CENT;
            end
            POS_YEAR_LO: begin
                if (pair_ok && pair_v <= MAX_PAIR) o_chk.wr_year = 1'b1;
                else                               o_chk.err     = ERR_YEAR;
            end
            POS_HOUR_LO: begin
                if (pair_ok && pair_v <= MAX_HOUR) o_chk.wr_hour = 1'b1;
                else                               o_chk.err     = ERR_HOUR;
            end
            POS_MIN_LO: begin
                if (pair_ok && pair_v <= MAX_MINSEC) o_chk.wr_minute = 1'b1;
                else                                 o_chk.err       = ERR_MIN;
            end
            POS_SEC_LO: begin
                if (pair_ok && pair_v <= MAX_MINSEC) o_chk.wr_second = 1'b1;
                else                                 o_chk.err       = ERR_SEC;
            end
            POS_GMT: begin
                // case-insensitive " GMT"
                if ((word | LOWER_MASK) != GMT_WORD) o_chk.err = ERR_GMT;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/core/rdp_parse_state.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rdp_parse_state
// Parser state registers and the result formed from each processed byte.
// ============================================================================
module rdp_parse_state
    import rdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_result     o_res
);

    logic [4:0]  r_pos,    n_pos;
    logic [3:0]  r_err,    n_err;
    logic [23:0] r_recent, n_recent;
    logic [3:0]  r_tens,   n_tens;
    logic [6:0]  r_cent,   n_cent;
    t_fields     r_fld,    n_fld;
    t_chk        chk;
    logic        take;

    rdp_byte_check u_check (
        .i_pos    (r_pos),
        .i_byte   (i_byte),
        .i_recent (r_recent),
        .i_tens   (r_tens),
        .i_cent   (r_cent),
        .o_chk    (chk)
    );

    assign take = r_pos < DATE_LEN;

    always_comb begin
        n_pos    = r_pos;
        n_err    = r_err;
        n_recent = r_recent;
        n_tens   = r_tens;
        n_cent   = r_cent;
        n_fld    = r_fld;
        if (take) begin
            n_pos    = r_pos + 5'd1;
            n_err    = (r_err == ERR_NONE) ? chk.err : r_err;
            n_recent = {i_byte, r_recent[23:8]};
            if (chk.wr_tens)   n_tens       = chk.tens;
            if (chk.wr_cent)   n_cent       = chk.cent;
            if (chk.wr_wday)   n_fld.wday   = chk.fld.wday;
            if (chk.wr_day)    n_fld.day    = chk.fld.day;
            if (chk.wr_month)  n_fld.month  = chk.fld.month;
            if (chk.wr_year)   n_fld.year   = chk.fld.year;
            if (chk.wr_hour)   n_fld.hour   = chk.fld.hour;
            if (chk.wr_minute) n_fld.minute = chk.fld.minute;
            if (chk.wr_second) n_fld.second = chk.fld.second;
        end
    end

    // Result as seen after this byte; short text wins over a latched error
    always_comb begin
        o_res.code = (n_pos < DATE_LEN) ? ERR_SHORT : n_err;
        o_res.ok   = (o_res.code == ERR_NONE);
        o_res.fld  = o_res.ok ? n_fld : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_pos    <= '0;
            r_err    <= ERR_NONE;
            r_recent <= '0;
            r_tens   <= '0;
            r_cent   <= '0;
            r_fld    <= '0;
        end else if (i_adv) begin
            r_pos    <= n_pos;
            r_err    <= n_err;
            r_recent <= n_recent;
            r_tens   <= n_tens;
            r_cent   <= n_cent;
            r_fld    <= n_fld;
        end
    end

endmodule

@@ rtl/core/rfc1123_date_parser.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rfc1123_date_parser
// Byte-serial parser for fixed-form date headers ("Sun, 06 Nov 1994 08:49:37 GMT").
// ============================================================================
// Usage:
//   Slave stream: one ASCII character per beat in s_axis_tdata[7:0];
//   s_axis_tlast marks the final character of the header body. Bytes past
//   the 29th are ignored.
//   Master stream: one beat per header, sent for the slave beat with tlast.
//   It carries status, the first error code (1 = too short) and the parsed
//   fields; fields read zero whenever status is not ok.
//   Datapath: a beat lands in the input register, then the position check
//   and field update run between that register and the state/result
//   registers, so a result is captured in the result register when its
//   tlast beat leaves the input register and the result register is free.
//   Throughput: one byte per cycle, except that a tlast byte waits while
//   the result register is full and m_axis_tready is low.
//   Stall: while the result register is full and m_axis_tready is low, a
//   non-last byte still drains into the parser; a tlast byte waits in the
//   input register and s_axis_tready drops until the result is taken.
//   Reset (synchronous, active low): clears both registers' valid bits and
//   the parser state; after each result the parser state clears again.
// ============================================================================
module rfc1123_date_parser
    import rdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] status_ok, [4:1] error_code, [7:5] weekday, [12:8] day_of_month,
    // [16:13] month_index, [30:17] years_since_1900, [35:31] hour_value,
    // [41:36] minute_value, [47:42] second_value
    output logic [47:0] m_axis_tdata
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_vld;
    t_result    r_out;
    t_result    res;
    logic       adv;

    // A byte leaves the input register unless it is a tlast byte blocked by
    // a result that has not been taken yet.
    assign adv           = r_in_vld && (!r_in_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    rdp_parse_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.fld.second, r_out.fld.minute, r_out.fld.hour,
                            r_out.fld.year, r_out.fld.month, r_out.fld.day,
                            r_out.fld.wday, r_out.code, r_out.ok};

endmodule

@@ sim/rfc1123_date_parser_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rfc1123_date_parser_test
// Self-checking bench: streams date headers byte by byte into the parser and
// compares every result beat against an in-bench model of the byte checks.
// ============================================================================
module rfc1123_date_parser_test;
    import rdp_pkg::*;

    // Predicts the result beat of each header and checks the parser output.
    class date_predictor;
        typedef struct {
            logic        ok;
            logic [3:0]  code;
            logic [2:0]  wday;
            logic [4:0]  day;
            logic [3:0]  month;
            logic [13:0] year;
            logic [4:0]  hour;
            logic [5:0]  minute;
            logic [5:0]  second;
        } date_result_t;

        string wday_names[7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
        string month_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                   "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

        date_result_t expected_dates[$];
        int unsigned  mismatches;
        int unsigned  results_seen;

        // parser state
        logic [4:0]   pos;
        logic [3:0]   first_err;
        logic [23:0]  recent;
        logic [3:0]   tens;
        logic [6:0]   cent;
        date_result_t fld;

        function new();
            clear();
        endfunction

        function void clear();
            pos = '0;
            first_err = ERR_NONE;
            recent = '0;
            tens = '0;
            cent = '0;
            fld = '{default: '0};
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function logic [31:0] name_word(string s, logic [7:0] sep);
            return {sep, 8'(s[2]), 8'(s[1]), 8'(s[0])};
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        // value of a digit pair, 255 when either byte is not a digit
        function int pair_value(logic [7:0] b);
            if (tens > 4'd9 || !is_digit(b)) return 255;
            return tens * 10 + (b - CH_ZERO);
        endfunction

        function logic [3:0] take_byte(logic [7:0] b);
            logic [31:0] word;
            logic [3:0]  err;
            int          v;
            word = {b, recent};
            err = ERR_NONE;
            case (pos)
                POS_WDAY: begin
                    err = ERR_WDAY;
                    for (int i = 0; i < 7; i++) begin
                        if (word == name_word(wday_names[i], 8'h2c)) begin
                            fld.wday = 3'(i);
                            err = ERR_NONE;
                        end
                    end
                end
                POS_MONTH: begin
                    err = ERR_MONTH;
                    for (int i = 0; i < 12; i++) begin
                        if (word == name_word(month_names[i], CH_SPACE)) begin
                            fld.month = 4'(i);
                            err = ERR_NONE;
                        end
                    end
                end
                POS_SP_WDAY: if (b != CH_SPACE) err = ERR_SP_WDAY;
                POS_SP_DAY:  if (b != CH_SPACE) err = ERR_SP_DAY;
                POS_SP_YEAR: if (b != CH_SPACE) err = ERR_SP_YEAR;
                POS_COLON1:  if (b != CH_COLON) err = ERR_COLON1;
                POS_COLON2:  if (b != CH_COLON) err = ERR_COLON2;
                POS_DAY_HI, POS_CENT_HI, POS_YEAR_HI, POS_HOUR_HI, POS_MIN_HI,
                POS_SEC_HI: begin
                    tens = is_digit(b) ? 4'(b - CH_ZERO) : NOT_DIGIT;
                end
                POS_DAY_LO: begin
                    v = pair_value(b);
                    if (v > 31) err = ERR_DAY; else fld.day = 5'(v);
                end
                POS_CENT_LO: begin
                    v = pair_value(b);
                    if (v > 99) err = ERR_CENT; else cent = 7'(v);
                end
                POS_YEAR_LO: begin
                    v = pair_value(b);
                    if (v > 99) err = ERR_YEAR;
                    else fld.year = 14'(int'(cent) * 100 + v - 1900);
                end
                POS_HOUR_LO: begin
                    v = pair_value(b);
                    if (v > 23) err = ERR_HOUR; else fld.hour = 5'(v);
                end
                POS_MIN_LO: begin
                    v = pair_value(b);
                    if (v > 59) err = ERR_MIN; else fld.minute = 6'(v);
                end
                POS_SEC_LO: begin
                    v = pair_value(b);
                    if (v > 59) err = ERR_SEC; else fld.second = 6'(v);
                end
                POS_GMT: if ((word | LOWER_MASK) != GMT_WORD) err = ERR_GMT;
                default: ;
            endcase
            recent = {b, recent[23:8]};
            return err;
        endfunction

        // called for every accepted input beat
        function void note_byte(logic [7:0] b, logic last);
            logic [3:0]   e;
            date_result_t r;
            if (pos < DATE_LEN) begin
                e = take_byte(b);
                if (first_err == ERR_NONE) first_err = e;
                pos = pos + 5'd1;
            end
            if (last) begin
                r = '{default: '0};
                r.code = (pos < DATE_LEN) ? ERR_SHORT : first_err;
                r.ok = (r.code == ERR_NONE);
                if (r.ok) begin
                    r = fld;
                    r.ok = 1'b1;
                    r.code = ERR_NONE;
                end
                expected_dates.push_back(r);
                clear();
            end
        endfunction

        task report_mismatch(string what);
            $display("ERROR: result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(logic [47:0] d);
            date_result_t w;
            results_seen++;
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", d));
                return;
            end
            w = expected_dates.pop_front();
            check_field("status_ok", d[0], w.ok);
            check_field("error_code", d[4:1], w.code);
            check_field("weekday", d[7:5], w.wday);
            check_field("day_of_month", d[12:8], w.day);
            check_field("month_index", d[16:13], w.month);
            check_field("years_since_1900", d[30:17], w.year);
            check_field("hour_value", d[35:31], w.hour);
            check_field("minute_value", d[41:36], w.minute);
            check_field("second_value", d[47:42], w.second);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic        s_tlast = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // status, code, then fields (see DUT port list)

    date_predictor sb;
    logic [7:0]    hdr[$];          // header being built
    int unsigned   bytes_sent;
    int unsigned   headers_sent;
    bit            hold_req;        // asks the receiver for one long stall
    bit            calm;            // no idling on either side

    always #1 i_clk = ~i_clk;

    rfc1123_date_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver: ready runs, random stall bursts, one long hold
    initial begin
        int unsigned hold_cnt;
        forever begin
            @(posedge i_clk);
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 1) == 0) begin
                // ready stays low through this wait and is raised again at the top of the loop
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
    endtask

    task automatic push_pair(int v);
        hdr.push_back(8'(CH_ZERO + v / 10));
        hdr.push_back(8'(CH_ZERO + v % 10));
    endtask

    // flip[i] toggles the case bit of byte i of " GMT" (a space becomes NUL)
    task automatic push_date(int w, int d, int m, int c, int y, int h, int mi, int s,
                             logic [3:0] flip);
        logic [7:0] gmt [4];
        gmt = '{CH_SPACE, 8'h47, 8'h4d, 8'h54};
        push_text(sb.wday_names[w]);
        push_text(", ");
        push_pair(d);
        push_text(" ");
        push_text(sb.month_names[m]);
        push_text(" ");
        push_pair(c);
        push_pair(y);
        push_text(" ");
        push_pair(h);
        push_text(":");
        push_pair(mi);
        push_text(":");
        push_pair(s);
        for (int i = 0; i < 4; i++) hdr.push_back(gmt[i] ^ (flip[i] ? 8'h20 : 8'h00));
    endtask

    function automatic int rnd_pair(int lim);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, lim);
    endfunction

    task automatic send_beat(logic [7:0] b, logic last);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_header();
        bit gappy;
        gappy = !calm && $urandom_range(0, 2) != 0;
        foreach (hdr[i]) begin
            if (gappy && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            send_beat(hdr[i], i == hdr.size() - 1);
        end
        headers_sent++;
        hdr.delete();
    endtask

    // mostly well-formed dates with random content, some damaged or noise
    task automatic build_random_header();
        int idx;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 40)) hdr.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_date($urandom_range(0, 6), rnd_pair(31), $urandom_range(0, 11),
                  $urandom_range(0, 99), $urandom_range(0, 99), rnd_pair(23),
                  rnd_pair(59), rnd_pair(59),
                  ($urandom_range(0, 1) == 0) ? 4'b0000 : 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                idx = $urandom_range(0, 28);
                if ($urandom_range(0, 1) == 0) hdr[idx] = 8'($urandom_range(0, 255));
                else hdr[idx] = hdr[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            hdr = hdr[0:$urandom_range(0, 27)];
        end else if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 6)) hdr.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: nominal, all-max with lower-case zone and trailing bytes,
        // all-zero (year before 1900), and one-byte headers
        push_date(0, 6, 10, 19, 94, 8, 49, 37, 4'b0000);
        send_header();
        push_date(6, 31, 11, 99, 99, 23, 59, 59, 4'b1110);
        push_text("xx");
        send_header();
        push_date(1, 0, 0, 0, 0, 0, 0, 0, 4'b1011);
        send_header();
        hdr.push_back(8'hff);
        send_header();
        hdr.push_back(8'h00);
        send_header();

        // random
        while (bytes_sent < 650) begin
            if (headers_sent == 12) hold_req = 1'b1;
            calm = bytes_sent >= 560;
            build_random_header();
            send_header();
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rdp_pkg.sv
rtl/core/rdp_byte_check.sv
rtl/core/rdp_parse_state.sv
rtl/core/rfc1123_date_parser.sv
sim/rfc1123_date_parser_test.sv
